// File: hw/rtl/osa_pkg.sv
// ----------------------------------------------------------------------------
// osa_pkg
// Shared types and codes for the optimal string alignment distance block.
// ----------------------------------------------------------------------------
package osa_pkg;

  // Request function codes
  localparam logic [1:0] FUNC_REF  = 2'd0;  // append reference character
  localparam logic [1:0] FUNC_FRAG = 2'd1;  // append fragment character
  localparam logic [1:0] FUNC_FIN  = 2'd2;  // finish, emit distance

  localparam int unsigned SYM_W  = 8;
  localparam int unsigned DIST_W = 9;

  // Control part of a token travelling down the cell chain
  typedef struct packed {
    logic             vld;        // token present
    logic             fin;        // finish token (else fragment column)
    logic             first;      // first fragment column of the pair
    logic             swap_ok;    // sender is a reference cell (row >= 1)
    logic             use_cells;  // finish: take value from loaded cells
    logic             bad;        // finish: characters were dropped
    logic [SYM_W-1:0] sym;        // fragment character of this column
    logic [SYM_W-1:0] psym;       // fragment character of previous column
    logic [SYM_W-1:0] rprev;      // reference character of the sender
  } ctl_t;

endpackage

// File: hw/rtl/osa_edit_distance.sv
// ----------------------------------------------------------------------------
// osa_edit_distance
// Optimal string alignment distance over a systolic row of MAX_LEN cells.
// ----------------------------------------------------------------------------
// Reference and fragment characters are taken one per cycle while the block
// does not stall. Each reference character is stored in its own cell; each
// fragment character enters the row as a column token and moves one cell per
// cycle, so columns overlap as a wavefront. A finish request follows the last
// column through every cell register of the row into the output register.
// While the finish travels, the block stalls requests; afterwards it takes
// new characters even while the result still waits to be taken, but holds a
// further finish until the output is free.
module osa_edit_distance #(
  parameter int unsigned MAX_LEN = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    func_i,
  input  logic [osa_pkg::SYM_W-1:0]     symbol_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [osa_pkg::DIST_W-1:0]    distance_o,
  output logic                          bad_input_o
);

  localparam int unsigned DW     = $clog2(MAX_LEN + 1);
  localparam int unsigned DIST_W = osa_pkg::DIST_W;

  logic [DW-1:0]                n_q, m_q;
  logic [osa_pkg::SYM_W-1:0]    psym_q;
  logic                         err_q, fin_busy_q;
  logic                         out_valid_q, bad_q;
  logic [DIST_W-1:0]            dist_q;
  logic                         acc, acc_ref, acc_frag, acc_fin;
  logic                         ref_ok, frag_ok, fin_out;

  osa_pkg::ctl_t                ctl_w   [MAX_LEN+1];
  logic [DW-1:0]                up_w    [MAX_LEN+1];
  logic [DW-1:0]                diag_w  [MAX_LEN+1];
  logic [DW-1:0]                diag2_w [MAX_LEN+1];

  // Handshake
  assign in_stall_o = fin_busy_q || ((func_i == osa_pkg::FUNC_FIN) && out_valid_q);
  assign acc        = in_valid_i && !in_stall_o;
  assign acc_ref    = acc && (func_i == osa_pkg::FUNC_REF);
  assign acc_frag   = acc && (func_i == osa_pkg::FUNC_FRAG);
  assign acc_fin    = acc && (func_i == osa_pkg::FUNC_FIN);
  assign ref_ok     = (m_q == '0) && (n_q < DW'(MAX_LEN));
  assign frag_ok    = (m_q < DW'(MAX_LEN));

  // Token entering the first cell
  always_comb begin
    ctl_w[0]           = '0;
    ctl_w[0].vld       = (acc_frag && frag_ok) || acc_fin;
    ctl_w[0].fin       = acc_fin;
    ctl_w[0].first     = (m_q == '0);
    ctl_w[0].use_cells = (m_q != '0);
    ctl_w[0].bad       = err_q;
    ctl_w[0].sym       = symbol_i;
    ctl_w[0].psym      = psym_q;
    if (acc_fin) begin
      up_w[0] = (m_q == '0) ? n_q : m_q;
    end else begin
      up_w[0] = m_q + DW'(1);
    end
    diag_w[0]  = m_q;
    diag2_w[0] = '0;
  end

  // Row of cells
  for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
    osa_cell #(
      .VAL_W (DW)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .wr_en_i  (acc_ref && ref_ok && (n_q == DW'(k))),
      .wr_sym_i (symbol_i),
      .ctl_i    (ctl_w[k]),
      .up_i     (up_w[k]),
      .diag_i   (diag_w[k]),
      .diag2_i  (diag2_w[k]),
      .ctl_o    (ctl_w[k+1]),
      .up_o     (up_w[k+1]),
      .diag_o   (diag_w[k+1]),
      .diag2_o  (diag2_w[k+1])
    );
  end

  assign fin_out = ctl_w[MAX_LEN].vld && ctl_w[MAX_LEN].fin;

  // Pair bookkeeping, finish tracking and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q         <= '0;
      m_q         <= '0;
      psym_q      <= '0;
      err_q       <= 1'b0;
      fin_busy_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (acc_ref) begin
        if (ref_ok) begin
          n_q <= n_q + DW'(1);
        end else begin
          err_q <= 1'b1;
        end
      end
      if (acc_frag) begin
        if (frag_ok) begin
          m_q    <= m_q + DW'(1);
          psym_q <= symbol_i;
        end else begin
          err_q <= 1'b1;
        end
      end
      if (acc_fin) begin
        n_q        <= '0;
        m_q        <= '0;
        psym_q     <= '0;
        err_q      <= 1'b0;
        fin_busy_q <= 1'b1;
      end else if (fin_out) begin
        fin_busy_q <= 1'b0;
      end
      if (fin_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_out) begin
      dist_q <= DIST_W'(up_w[MAX_LEN]);
      bad_q  <= ctl_w[MAX_LEN].bad;
    end
  end

  assign out_valid_o = out_valid_q;
  assign distance_o  = dist_q;
  assign bad_input_o = bad_q;

endmodule

// File: hw/rtl/osa_cell.sv
// ----------------------------------------------------------------------------
// osa_cell
// One reference character of the systolic DP row: holds its character, its
// entry of the current column and the diagonal seen one column back.
// ----------------------------------------------------------------------------
module osa_cell #(
  parameter int unsigned VAL_W = 9
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        wr_en_i,
  input  logic [osa_pkg::SYM_W-1:0]   wr_sym_i,
  input  osa_pkg::ctl_t               ctl_i,
  input  logic [VAL_W-1:0]            up_i,
  input  logic [VAL_W-1:0]            diag_i,
  input  logic [VAL_W-1:0]            diag2_i,
  output osa_pkg::ctl_t               ctl_o,
  output logic [VAL_W-1:0]            up_o,
  output logic [VAL_W-1:0]            diag_o,
  output logic [VAL_W-1:0]            diag2_o
);

  logic [osa_pkg::SYM_W-1:0] ref_q;
  logic                      loaded_q;
  logic [VAL_W-1:0]          cur_q, dlast_q;
  logic [VAL_W-1:0]          old_val, new_val, fin_val;
  logic [VAL_W:0]            ins_w, del_w, rep_w, swp_w, best_w;
  logic                      match, swap_hit, frag_tok, fin_tok;
  osa_pkg::ctl_t             ctl_d, ctl_q;
  logic [VAL_W-1:0]          up_q, diag_q, diag2_q;

  assign frag_tok = ctl_i.vld && !ctl_i.fin;
  assign fin_tok  = ctl_i.vld && ctl_i.fin;

  // Previous-column entry; the first column starts at row index + 1
  assign old_val = ctl_i.first ? (diag_i + VAL_W'(1)) : cur_q;

  // DP update: insert, delete, replace and adjacent swap
  always_comb begin
    match    = (ref_q == ctl_i.sym);
    swap_hit = ctl_i.swap_ok && !ctl_i.first &&
               (ctl_i.rprev == ctl_i.sym) && (ref_q == ctl_i.psym);
    ins_w    = {1'b0, up_i} + (VAL_W+1)'(1);
    del_w    = {1'b0, old_val} + (VAL_W+1)'(1);
    rep_w    = {1'b0, diag_i} + (VAL_W+1)'(1);
    swp_w    = {1'b0, diag2_i} + (VAL_W+1)'(1);
    best_w   = (ins_w < del_w) ? ins_w : del_w;
    if (rep_w < best_w) begin
      best_w = rep_w;
    end
    if (swap_hit && (swp_w < best_w)) begin
      best_w = swp_w;
    end
    new_val = match ? diag_i : best_w[VAL_W-1:0];
  end

  // Finish token picks up this row's entry when the cell holds a character
  assign fin_val = (ctl_i.use_cells && loaded_q) ? cur_q : up_i;

  always_comb begin
    ctl_d         = ctl_i;
    ctl_d.swap_ok = 1'b1;
    ctl_d.rprev   = ref_q;
  end

  // Token control register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q    <= '0;
      loaded_q <= 1'b0;
    end else begin
      ctl_q <= ctl_d;
      if (wr_en_i) begin
        loaded_q <= 1'b1;
      end else if (fin_tok) begin
        loaded_q <= 1'b0;
      end
    end
  end

  // Payload: stored character, column entries, outgoing values
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      ref_q <= wr_sym_i;
    end
    if (frag_tok) begin
      cur_q   <= new_val;
      dlast_q <= diag_i;
    end
    up_q    <= fin_tok ? fin_val : new_val;
    diag_q  <= old_val;
    diag2_q <= dlast_q;
  end

  assign ctl_o   = ctl_q;
  assign up_o    = up_q;
  assign diag_o  = diag_q;
  assign diag2_o = diag2_q;

endmodule

// File: hw/rtl/osa_checker.sv
// ----------------------------------------------------------------------------
// osa_checker
// Port-level checks for the string alignment distance block.
// ----------------------------------------------------------------------------
module osa_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic [1:0]                  func_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [osa_pkg::DIST_W-1:0]  distance_o,
  input logic                        bad_input_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(distance_o) && $stable(bad_input_o))
    else $error("stalled result changed");

  // No finish is taken while a result is still waiting
  a_fin_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && (func_i == osa_pkg::FUNC_FIN) && out_valid_o |-> in_stall_o)
    else $error("finish accepted over a pending result");

  // A taken finish keeps the input stalled while it drains
  a_fin_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (func_i == osa_pkg::FUNC_FIN) |=> in_stall_o)
    else $error("input not stalled after finish");

  // A result only appears at the end of a finish drain
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without finish in flight");

endmodule

bind osa_edit_distance osa_checker u_osa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .func_i      (func_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .distance_o  (distance_o),
  .bad_input_o (bad_input_o)
);

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Checks the optimal string alignment distance block. Requests go in as
// reference, fragment, finish or unused codes. A column-by-column distance
// model predicts each finish result, and the results are scored in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_LEN     = 256;
  localparam logic [1:0]  FUNC_NONE   = 2'd3;  // unused code, ignored by the block
  localparam int          NUM_ITEMS   = 1400;
  localparam int          MIN_RESULTS = 48;
  localparam int          PHASE_PAIRS = 8;
  localparam int          HOLD_CYCLES = 2000;
  localparam int          CYCLE_LIMIT = 600000;
  localparam int          DIR_ROWS    = 25;

  typedef enum int {PH_QUIET, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH} phase_t;
  typedef enum int {ALPHA_SMALL, ALPHA_FULL, ALPHA_EDGE} alpha_t;
  typedef enum int {EDIT_SWAP, EDIT_REPLACE, EDIT_DROP, EDIT_ADD} edit_t;

  typedef struct {
    logic [osa_pkg::DIST_W-1:0] distance;
    logic                       bad;
  } osa_result_t;

  typedef struct packed {
    logic [1:0]                 func;
    logic [osa_pkg::SYM_W-1:0]  sym;
    logic                       typed;  // expected result given in the row
    logic [osa_pkg::DIST_W-1:0] distance;
    logic                       bad;
  } dir_row_t;

  // Short directed sequence; typed results only where obvious
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{osa_pkg::FUNC_FIN,  8'h00, 1'b1, 9'd0, 1'b0},  // both strings empty after reset
    '{osa_pkg::FUNC_REF,  8'h00, 1'b0, 9'd0, 1'b0},
    '{osa_pkg::FUNC_REF,  8'hFF, 1'b0, 9'd0, 1'b0},
    '{osa_pkg::FUNC_FIN,  8'hFF, 1'b1, 9'd2, 1'b0},  // empty fragment: reference length
    '{osa_pkg::FUNC_FRAG, 8'h41, 1'b0, 9'd0, 1'b0},  // fragment against empty reference
    '{osa_pkg::FUNC_FRAG, 8'hBE, 1'b0, 9'd0, 1'b0},
    '{osa_pkg::FUNC_FIN,  8'h00, 1'b0, 9'd0, 1'b0},
    '{osa_pkg::FUNC_REF,  8'h61, 1'b0, 9'd0, 1'b0},  // adjacent swap
    '{osa_pkg::FUNC_REF,  8'h62, 1'b0, 9'd0, 1'b0},
    '{osa_pkg::FUNC_FRAG, 8'h62, 1'b0, 9'd0, 1'b0},
    '{osa_pkg::FUNC_FRAG, 8'h61, 1'b0, 9'd0, 1'b0},
    '{osa_pkg::FUNC_FIN,  8'h00, 1'b0, 9'd0, 1'b0},
    '{osa_pkg::FUNC_REF,  8'h63, 1'b0, 9'd0, 1'b0},  // reference after fragment
    '{osa_pkg::FUNC_FRAG, 8'h63, 1'b0, 9'd0, 1'b0},
    '{osa_pkg::FUNC_REF,  8'h64, 1'b0, 9'd0, 1'b0},
    '{osa_pkg::FUNC_FIN,  8'h00, 1'b1, 9'd0, 1'b1},
    '{FUNC_NONE,          8'h55, 1'b0, 9'd0, 1'b0},  // unused code
    '{osa_pkg::FUNC_FIN,  8'hAA, 1'b1, 9'd0, 1'b0},
    '{osa_pkg::FUNC_REF,  8'h61, 1'b0, 9'd0, 1'b0},  // swap away from the edge
    '{osa_pkg::FUNC_REF,  8'h62, 1'b0, 9'd0, 1'b0},
    '{osa_pkg::FUNC_REF,  8'h63, 1'b0, 9'd0, 1'b0},
    '{osa_pkg::FUNC_FRAG, 8'h61, 1'b0, 9'd0, 1'b0},
    '{osa_pkg::FUNC_FRAG, 8'h63, 1'b0, 9'd0, 1'b0},
    '{osa_pkg::FUNC_FRAG, 8'h62, 1'b0, 9'd0, 1'b0},
    '{osa_pkg::FUNC_FIN,  8'h00, 1'b0, 9'd0, 1'b0}
  };

  // DUT ports
  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       in_valid_i  = 1'b0;
  logic                       in_stall_o;
  logic [1:0]                 func_i      = '0;
  logic [osa_pkg::SYM_W-1:0]  symbol_i    = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic [osa_pkg::DIST_W-1:0] distance_o;
  logic                       bad_input_o;

  // Typed expectation travelling with the request
  logic                       req_typed = 1'b0;
  logic [osa_pkg::DIST_W-1:0] req_dist  = '0;
  logic                       req_bad   = 1'b0;
  logic                       row_typed = 1'b0;
  logic [osa_pkg::DIST_W-1:0] row_dist  = '0;
  logic                       row_bad   = 1'b0;

  // Predictor state
  logic [osa_pkg::SYM_W-1:0] ref_chars [MAX_LEN];
  int                        ref_len  = 0;
  int                        frag_len = 0;
  int                        cur_col  [MAX_LEN+1];
  int                        prev_col [MAX_LEN+1];
  int                        new_col  [MAX_LEN+1];
  logic [osa_pkg::SYM_W-1:0] last_sym = '0;
  logic                      err_seen = 1'b0;

  osa_result_t               pending_q [$];
  logic [osa_pkg::SYM_W-1:0] ref_q [$];
  logic [osa_pkg::SYM_W-1:0] frag_q [$];

  int errors         = 0;
  int items_sent     = 0;
  int fin_taken      = 0;
  int cycle_cnt      = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  bit hold_req       = 1'b0;
  bit hold_started   = 1'b0;

  osa_edit_distance #(.MAX_LEN(MAX_LEN)) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .symbol_i    (symbol_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .distance_o  (distance_o),
    .bad_input_o (bad_input_o)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Advance the distance model by one request; returns 1 on a result
  function automatic bit osa_column_step(input logic [1:0] f,
                                         input logic [osa_pkg::SYM_W-1:0] s,
                                         output logic [osa_pkg::DIST_W-1:0] d,
                                         output logic b);
    int i;
    int ins;
    int del;
    int rep;
    d = '0;
    b = 1'b0;
    osa_column_step = 1'b0;
    case (f)
      osa_pkg::FUNC_REF: begin
        if (frag_len != 0 || ref_len >= MAX_LEN) begin
          err_seen = 1'b1;
        end else begin
          ref_chars[ref_len] = s;
          ref_len++;
        end
      end
      osa_pkg::FUNC_FRAG: begin
        if (frag_len >= MAX_LEN) begin
          err_seen = 1'b1;
        end else begin
          if (frag_len == 0) begin
            for (i = 0; i <= ref_len; i++) cur_col[i] = i;
          end
          new_col[0] = frag_len + 1;
          for (i = 0; i < ref_len; i++) begin
            if (ref_chars[i] == s) begin
              new_col[i+1] = cur_col[i];
            end else begin
              ins = new_col[i] + 1;
              del = cur_col[i+1] + 1;
              rep = cur_col[i] + 1;
              // transposition, never at the first row or column
              if (i >= 1 && frag_len >= 1 && ref_chars[i-1] == s &&
                  ref_chars[i] == last_sym && prev_col[i-1] + 1 < rep) begin
                rep = prev_col[i-1] + 1;
              end
              new_col[i+1] = (ins < del) ? ins : del;
              if (rep < new_col[i+1]) new_col[i+1] = rep;
            end
          end
          for (i = 0; i <= ref_len; i++) begin
            prev_col[i] = cur_col[i];
            cur_col[i]  = new_col[i];
          end
          last_sym = s;
          frag_len++;
        end
      end
      osa_pkg::FUNC_FIN: begin
        d = osa_pkg::DIST_W'((frag_len == 0) ? ref_len : cur_col[ref_len]);
        b = err_seen;
        ref_len  = 0;
        frag_len = 0;
        last_sym = '0;
        err_seen = 1'b0;
        osa_column_step = 1'b1;
      end
      default: ;
    endcase
  endfunction

  function automatic logic [osa_pkg::SYM_W-1:0] rand_sym(input alpha_t mode);
    case (mode)
      ALPHA_SMALL: rand_sym = 8'h61 + osa_pkg::SYM_W'($urandom_range(3));
      ALPHA_FULL:  rand_sym = osa_pkg::SYM_W'($urandom_range(255));
      default:     rand_sym = $urandom_range(1) ? 8'hFF : 8'h00;
    endcase
  endfunction

  // Predict on accepted requests, score accepted results
  always @(posedge clk_i) begin : scoreboard
    logic [osa_pkg::DIST_W-1:0] pd;
    logic                       pb;
    osa_result_t                res;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        if (osa_column_step(func_i, symbol_i, pd, pb)) begin
          res.distance = req_typed ? req_dist : pd;
          res.bad      = req_typed ? req_bad : pb;
          pending_q.push_back(res);
          fin_taken++;
        end
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_q.size() == 0) begin
          errors++;
          $display("%0t: result with nothing pending: distance %0d bad_input %0b",
                   $time, distance_o, bad_input_o);
        end else begin
          res = pending_q.pop_front();
          if (res.distance !== distance_o) begin
            errors++;
            $display("%0t: distance mismatch: expected %0d, actual %0d",
                     $time, res.distance, distance_o);
          end
          if (res.bad !== bad_input_o) begin
            errors++;
            $display("%0t: bad_input mismatch: expected %0b, actual %0b",
                     $time, res.bad, bad_input_o);
          end
        end
      end
    end
  end

  // Receiver stall, with one long hold-off
  always @(negedge clk_i) begin
    if (hold_req && !hold_started) begin
      hold_started <= 1'b1;
      hold_left    <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
    out_stall_i <= (hold_left > 0) || ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // Offer one request, with random idle cycles ahead of it
  task automatic send_req(input logic [1:0] f, input logic [osa_pkg::SYM_W-1:0] s);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      func_i     <= 2'($urandom);
      symbol_i   <= osa_pkg::SYM_W'($urandom);
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= f;
    symbol_i   <= s;
    req_typed  <= row_typed;
    req_dist   <= row_dist;
    req_bad    <= row_bad;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (f != FUNC_NONE) items_sent++;
  endtask

  // Sender pauses until every pending result is out
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic set_phase(input phase_t ph);
    @(posedge clk_i);
    send_idle_pct  = (ph == PH_SEND_IDLE) ? 57 : (ph == PH_BOTH) ? 11 : 0;
    recv_stall_pct = (ph == PH_RECV_STALL) ? 57 : (ph == PH_BOTH) ? 11 : 0;
  endtask

  // Reference of nref chars; fragment derived by edits or drawn freely
  task automatic build_pair(input int nref, input alpha_t mode, input bit derived,
                            input int nedits, input int nfrag);
    int k;
    int pos;
    logic [osa_pkg::SYM_W-1:0] t;
    ref_q.delete();
    frag_q.delete();
    for (k = 0; k < nref; k++) ref_q.push_back(rand_sym(mode));
    if (derived) begin
      frag_q = ref_q;
      for (k = 0; k < nedits; k++) begin
        pos = (frag_q.size() == 0) ? 0 : $urandom_range(frag_q.size() - 1);
        case (edit_t'($urandom_range(3)))
          EDIT_SWAP: begin
            if (pos + 1 < frag_q.size()) begin
              t             = frag_q[pos];
              frag_q[pos]   = frag_q[pos+1];
              frag_q[pos+1] = t;
            end
          end
          EDIT_REPLACE: if (frag_q.size() != 0) frag_q[pos] = rand_sym(mode);
          EDIT_DROP:    if (frag_q.size() != 0) frag_q.delete(pos);
          default:      frag_q.insert(pos, rand_sym(mode));
        endcase
      end
    end else begin
      for (k = 0; k < nfrag; k++) frag_q.push_back(rand_sym(mode));
    end
  endtask

  task automatic send_pair(input bit late_ref, input bit junk, input bit tail_frag);
    int k;
    for (k = 0; k < ref_q.size(); k++) send_req(osa_pkg::FUNC_REF, ref_q[k]);
    if (junk) send_req(FUNC_NONE, osa_pkg::SYM_W'($urandom_range(255)));
    for (k = 0; k < frag_q.size(); k++) send_req(osa_pkg::FUNC_FRAG, frag_q[k]);
    if (late_ref) send_req(osa_pkg::FUNC_REF, osa_pkg::SYM_W'($urandom_range(255)));
    if (tail_frag) begin
      // push the fragment past its length limit
      send_req(osa_pkg::FUNC_FRAG, osa_pkg::SYM_W'($urandom_range(255)));
      send_req(osa_pkg::FUNC_FRAG, osa_pkg::SYM_W'($urandom_range(255)));
    end
    send_req(osa_pkg::FUNC_FIN, osa_pkg::SYM_W'($urandom_range(255)));
  endtask

  initial begin : stimulus
    int k;
    int pair_cnt;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows, no idling
    for (k = 0; k < DIR_ROWS; k++) begin
      row_typed = DIR_TAB[k].typed;
      row_dist  = DIR_TAB[k].distance;
      row_bad   = DIR_TAB[k].bad;
      send_req(DIR_TAB[k].func, DIR_TAB[k].sym);
    end
    row_typed = 1'b0;

    // Random pairs, idling phases rotate
    pair_cnt = 0;
    while (items_sent < NUM_ITEMS || fin_taken < MIN_RESULTS) begin
      if (pair_cnt % PHASE_PAIRS == 0) begin
        drain();
        set_phase(phase_t'((pair_cnt / PHASE_PAIRS) % 4));
        if (pair_cnt == 0) hold_req = 1'b1;
      end
      if (pair_cnt == 5) begin
        // full reference plus overflow, near-copy fragment plus overflow
        build_pair(MAX_LEN + 2, ALPHA_SMALL, 1'b1, 4, 0);
        send_pair(1'b0, 1'b0, 1'b1);
      end else if (pair_cnt == 37) begin
        // empty reference, full fragment: largest distance
        build_pair(0, ALPHA_FULL, 1'b0, 0, MAX_LEN);
        send_pair(1'b0, 1'b0, 1'b1);
      end else begin
        build_pair($urandom_range(10), alpha_t'($urandom_range(3) % 3),
                   $urandom_range(9) < 7, $urandom_range(3), $urandom_range(10));
        send_pair($urandom_range(9) == 0, $urandom_range(9) == 0, 1'b0);
      end
      pair_cnt++;
    end

    drain();
    repeat (MAX_LEN + 20) @(posedge clk_i);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
